// File: rtl/sem_pkg.sv
package sem_pkg;

  localparam int MaxWidth   = 1024;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int WidthRegW  = 11;
  localparam int HeightRegW = 16;
  localparam int CfgW       = 16;
  localparam int RowW       = 17;
  localparam int WarmW      = ColW + 1;
  localparam int PixW       = 24;
  localparam int ResetWidth  = 640;
  localparam int ResetHeight = 480;
  localparam int MagMax      = 255;
  // Largest sum of squares that still rounds to MagMax or less.
  localparam int RoundLimit  = MagMax * MagMax + MagMax;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  // One color plane of the 3x3 window, index row*3+col, row 0 on top.
  typedef logic [8:0][7:0] chwin_t;

  typedef struct packed {
    logic       start;
    logic [8:0] live;
  } mag_req_t;

endpackage

// File: rtl/sem_in_if.sv
interface sem_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, action, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, action, in_red, in_green, in_blue, output ready);
endinterface

// File: rtl/sem_out_if.sv
interface sem_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_red;
  logic [7:0] edge_green;
  logic [7:0] edge_blue;
  logic       frame_end;

  modport source (output valid, edge_red, edge_green, edge_blue, frame_end, input ready);
  modport sink   (input valid, edge_red, edge_green, edge_blue, frame_end, output ready);
endinterface

// File: rtl/sem_ram.sv
module sem_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/sem_mag.sv
module sem_mag (
  input  logic              clk,
  input  logic              rst_n,
  input  sem_pkg::mag_req_t req,
  input  sem_pkg::chwin_t   win,
  output logic              done,
  output logic [7:0]        mag
);

  typedef enum logic [4:0] {
    M_IDLE = 5'b00001,
    M_SQX  = 5'b00010,
    M_SQY  = 5'b00100,
    M_ROOT = 5'b01000,
    M_FIN  = 5'b10000
  } mstate_t;

  mstate_t            state_r, state_nxt;
  logic signed [10:0] gx_r, gx_nxt, gy_r, gy_nxt;
  logic [19:0]        nx_r, nx_nxt;
  logic [15:0]        nsh_r, nsh_nxt;
  logic               sat_r, sat_nxt;
  logic [8:0]         rem_r, rem_nxt;
  logic [7:0]         root_r, root_nxt;
  logic [2:0]         cnt_r, cnt_nxt;

  logic [7:0]         v [9];
  logic [10:0]        px, nx, py, ny;
  logic signed [21:0] sq_x, sq_y;
  logic [20:0]        nsum;
  logic [10:0]        cur, trial;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      v[k] = req.live[k] ? win[k] : 8'd0;
    end
    px = 11'(v[2]) + 11'({v[5], 1'b0}) + 11'(v[8]);
    nx = 11'(v[0]) + 11'({v[3], 1'b0}) + 11'(v[6]);
    py = 11'(v[6]) + 11'({v[7], 1'b0}) + 11'(v[8]);
    ny = 11'(v[0]) + 11'({v[1], 1'b0}) + 11'(v[2]);
  end

  assign sq_x  = gx_r * gx_r;
  assign sq_y  = gy_r * gy_r;
  assign nsum  = 21'(nx_r) + 21'(sq_y[19:0]);
  assign cur   = {rem_r, nsh_r[15:14]};
  assign trial = {1'b0, root_r, 2'b01};

  always_comb begin
    state_nxt = state_r;
    gx_nxt    = gx_r;
    gy_nxt    = gy_r;
    nx_nxt    = nx_r;
    nsh_nxt   = nsh_r;
    sat_nxt   = sat_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      M_IDLE: begin
        if (req.start) begin
          gx_nxt    = $signed(px) - $signed(nx);
          gy_nxt    = $signed(py) - $signed(ny);
          state_nxt = M_SQX;
        end
      end
      M_SQX: begin
        nx_nxt    = sq_x[19:0];
        state_nxt = M_SQY;
      end
      M_SQY: begin
        sat_nxt   = nsum > 21'(sem_pkg::RoundLimit);
        nsh_nxt   = nsum[15:0];
        rem_nxt   = '0;
        root_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = M_ROOT;
      end
      M_ROOT: begin
        // one root bit per cycle, two radicand bits shifted in
        if (cur >= trial) begin
          rem_nxt  = 9'(cur - trial);
          root_nxt = {root_r[6:0], 1'b1};
        end else begin
          rem_nxt  = cur[8:0];
          root_nxt = {root_r[6:0], 1'b0};
        end
        nsh_nxt = {nsh_r[13:0], 2'b00};
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          state_nxt = M_FIN;
        end
      end
      M_FIN: begin
        state_nxt = M_IDLE;
      end
      default: begin
        state_nxt = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    gx_r   <= gx_nxt;
    gy_r   <= gy_nxt;
    nx_r   <= nx_nxt;
    nsh_r  <= nsh_nxt;
    sat_r  <= sat_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign done = (state_r == M_FIN);
  // round up when the remainder exceeds the root
  assign mag  = sat_r ? 8'(sem_pkg::MagMax) : root_r + 8'(rem_r > {1'b0, root_r});

endmodule

// File: rtl/sobel_edge_magnitude_rgb.sv
// 3x3 Sobel edge magnitude on RGB raster frames, one pixel word in, at most
// one result word out per input word. Each color plane gets its own gx/gy
// kernels with out-of-frame neighbors taken as zero; the magnitude is the
// rounded square root of gx^2+gy^2, saturated to 255. The result for pixel p
// leaves when the word at raster position p+image_width+1 is accepted, so
// after the last pixel send image_width+1 flush words (action=1) to drain the
// frame; frame_end marks the last pixel, and the counters then restart.
// A flush word before the last pixel is dropped; a pixel word after it counts
// as flush. The two line buffers share one 48-bit synchronous RAM of
// MaxWidth entries, read at the current column and written back in the next
// cycle. A word that gives no result is accepted and then does the RAM read
// and window update; a word that gives a result then also passes the three
// per-plane magnitude units (gradient, squaring of gx and of gy with the
// sum, and an 8-bit bit-serial square root) and the output hand-off. The output
// register lets the next word enter while a result waits. Writing either
// configuration register restarts the frame.
module sobel_edge_magnitude_rgb (
  input  logic                                 clk,
  input  logic                                 rst_n,
  sem_in_if.sink                               in_s,
  sem_out_if.source                            out_m,
  input  logic                                 cfg_we,
  input  sem_pkg::reg_idx_t                    cfg_idx,
  input  logic [sem_pkg::CfgW-1:0]             cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_GO   = 5'b00100,
    S_WAIT = 5'b01000,
    S_PUT  = 5'b10000
  } state_t;

  localparam int ColW = sem_pkg::ColW;

  function automatic logic [sem_pkg::WidthRegW-1:0] clamp_width(
    logic [sem_pkg::CfgW-1:0] v);
    logic [sem_pkg::WidthRegW-1:0] w;
    w = v[sem_pkg::WidthRegW-1:0];
    if (w == '0) begin
      w = sem_pkg::WidthRegW'(1);
    end else if (32'(w) > sem_pkg::MaxWidth) begin
      w = sem_pkg::WidthRegW'(sem_pkg::MaxWidth);
    end
    return w;
  endfunction

  state_t                          state_r, state_nxt;
  logic [sem_pkg::WidthRegW-1:0]   w_r;
  logic [sem_pkg::HeightRegW-1:0]  h_r;
  logic [ColW-1:0]                 col_r;
  logic [sem_pkg::RowW-1:0]        row_r;
  logic [sem_pkg::WarmW-1:0]       warm_r;
  logic [sem_pkg::HeightRegW-1:0]  er_r;
  logic [ColW-1:0]                 ec_r;
  logic [8:0][sem_pkg::PixW-1:0]   win_r;
  logic [sem_pkg::PixW-1:0]        pix_r;
  logic                            last_r;
  logic [2:0][7:0]                 res_r;
  logic                            out_valid_r;
  logic [2:0][7:0]                 out_mag_r;
  logic                            out_end_r;

  logic                            accept, in_frame, emit, col_wrap, ec_wrap, is_last;
  logic                            slot_free, restart;
  logic [2*sem_pkg::PixW-1:0]      rdata;
  logic [8:0]                      live;
  sem_pkg::mag_req_t               req;
  sem_pkg::chwin_t                 cwin [3];
  logic [2:0]                      lane_done;
  logic [7:0]                      lane_mag [3];

  assign accept    = in_s.valid && in_s.ready;
  assign in_frame  = row_r < sem_pkg::RowW'(h_r);
  assign col_wrap  = 12'(col_r) == 12'(w_r) - 12'd1;
  assign ec_wrap   = 12'(ec_r) == 12'(w_r) - 12'd1;
  assign emit      = 12'(warm_r) == 12'(w_r) + 12'd1;
  assign is_last   = (er_r == h_r - 16'd1) && ec_wrap;
  assign slot_free = !out_valid_r || out_m.ready;
  assign restart   = (state_r == S_PUT) && slot_free && last_r;

  // border mask for the pixel being emitted
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        live[i*3+j] = !((i == 0 && er_r == '0) ||
                        (i == 2 && er_r == h_r - 16'd1) ||
                        (j == 0 && ec_r == '0) ||
                        (j == 2 && ec_wrap));
      end
    end
  end

  assign req.start = (state_r == S_GO);
  assign req.live  = live;

  // upper line in the top half, middle line in the bottom half
  sem_ram #(
    .Width (2 * sem_pkg::PixW),
    .Depth (sem_pkg::MaxWidth)
  ) u_lines (
    .clk   (clk),
    .we    (state_r == S_RD),
    .waddr (col_r),
    .wdata ({rdata[sem_pkg::PixW-1:0], pix_r}),
    .raddr (col_r),
    .rdata (rdata)
  );

  for (genvar c = 0; c < 3; c++) begin : g_lane
    always_comb begin
      for (int k = 0; k < 9; k++) begin
        cwin[c][k] = win_r[k][(2-c)*8 +: 8];
      end
    end
    sem_mag u_mag (
      .clk   (clk),
      .rst_n (rst_n),
      .req   (req),
      .win   (cwin[c]),
      .done  (lane_done[c]),
      .mag   (lane_mag[c])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && !(in_frame && in_s.action)) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = emit ? S_GO : S_IDLE;
      end
      S_GO: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (&lane_done) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      w_r         <= sem_pkg::WidthRegW'(sem_pkg::ResetWidth);
      h_r         <= sem_pkg::HeightRegW'(sem_pkg::ResetHeight);
      col_r       <= '0;
      row_r       <= '0;
      warm_r      <= '0;
      er_r        <= '0;
      ec_r        <= '0;
      win_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_m.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_RD) begin
        // shift the window left and load the new right column
        for (int i = 0; i < 3; i++) begin
          win_r[i*3]   <= win_r[i*3+1];
          win_r[i*3+1] <= win_r[i*3+2];
        end
        win_r[2] <= rdata[2*sem_pkg::PixW-1:sem_pkg::PixW];
        win_r[5] <= rdata[sem_pkg::PixW-1:0];
        win_r[8] <= pix_r;
        if (col_wrap) begin
          col_r <= '0;
          row_r <= row_r + sem_pkg::RowW'(1);
        end else begin
          col_r <= col_r + ColW'(1);
        end
        if (!emit) begin
          warm_r <= warm_r + sem_pkg::WarmW'(1);
        end
      end
      if (state_r == S_PUT && slot_free) begin
        out_valid_r <= 1'b1;
        if (ec_wrap) begin
          ec_r <= '0;
          er_r <= er_r + 16'd1;
        end else begin
          ec_r <= ec_r + ColW'(1);
        end
      end
      if (restart || cfg_we) begin
        col_r  <= '0;
        row_r  <= '0;
        warm_r <= '0;
        er_r   <= '0;
        ec_r   <= '0;
        win_r  <= '0;
      end
      if (cfg_we) begin
        case (cfg_idx)
          sem_pkg::REG_WIDTH:  w_r <= clamp_width(cfg_wdata);
          sem_pkg::REG_HEIGHT: h_r <= (cfg_wdata == '0) ? 16'd1 : cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && accept) begin
      pix_r <= in_frame ? {in_s.in_red, in_s.in_green, in_s.in_blue} : '0;
    end
    if (state_r == S_GO) begin
      last_r <= is_last;
    end
    if (state_r == S_WAIT) begin
      for (int c = 0; c < 3; c++) begin
        res_r[c] <= lane_mag[c];
      end
    end
    if (state_r == S_PUT && slot_free) begin
      out_mag_r <= res_r;
      out_end_r <= last_r;
    end
  end

  assign in_s.ready       = (state_r == S_IDLE);
  assign out_m.valid      = out_valid_r;
  assign out_m.edge_red   = out_mag_r[0];
  assign out_m.edge_green = out_mag_r[1];
  assign out_m.edge_blue  = out_mag_r[2];
  assign out_m.frame_end  = out_end_r;

endmodule

// File: rtl/sem_checker.sv
module sem_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_action,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic       out_end
);

  // hold a stalled result word
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_red, out_green, out_blue, out_end}))
    else $error("stalled result word changed");

  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // after a pixel word is accepted, the block drops input ready while it reads the line buffers
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_action |=> !in_ready)
    else $error("input ready right after a pixel word");

  // a result never appears the cycle after an accept
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result word too early after accept");

endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_s.valid),
  .in_ready  (in_s.ready),
  .in_action (in_s.action),
  .out_valid (out_m.valid),
  .out_ready (out_m.ready),
  .out_red   (out_m.edge_red),
  .out_green (out_m.edge_green),
  .out_blue  (out_m.edge_blue),
  .out_end   (out_m.frame_end)
);
